@@ rtl/core/rpfe_pkg.sv @@
`default_nettype none
package rpfe_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'hf0;
  localparam logic [7:0] B0_KEEP     = 8'he0;
  localparam logic [7:0] CRC_INIT    = 8'h1f;
  localparam logic [4:0] CRC_XOR_OUT = 5'h1f;

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_IDLE = 1'b1;

  // Byte positions inside one frame: four syncs from LONG_START or two from SHORT_START, then eight nibble codes.
  localparam logic [3:0] LONG_START  = 4'd0;
  localparam logic [3:0] SHORT_START = 4'd2;
  localparam logic [3:0] CODE_START  = 4'd4;
  localparam logic [3:0] LAST_IDX    = 4'd11;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [31:0] frame;
    logic        long_sync;
    logic        gap;
  } entry_t;

  localparam logic [4:0] STEP_IMAGES [8] = '{
    5'h0e, 5'h1c, 5'h11, 5'h0b, 5'h16, 5'h05, 5'h0a, 5'h14
  };

  localparam logic [7:0] NIBBLE_CODE [16] = '{
    8'h66, 8'h56, 8'ha6, 8'h6a, 8'h96, 8'h36, 8'h5a, 8'haa,
    8'h9a, 8'hb2, 8'h4d, 8'h65, 8'h4b, 8'h55, 8'ha5, 8'h2d
  };

  function automatic logic [4:0] crc_step(input logic [7:0] v);
    logic [4:0] r;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      if (v[b]) begin
        r = r ^ STEP_IMAGES[b];
      end
    end
    return r;
  endfunction

  // Replaces the low five bits of byte0 with the CRC over the packet.
  function automatic logic [31:0] frame_packet(input logic [31:0] w);
    logic [7:0] b0;
    logic [4:0] crc;
    b0  = w[7:0] & B0_KEEP;
    crc = crc_step(b0 ^ CRC_INIT);
    crc = crc_step({3'b000, crc} ^ w[15:8]);
    crc = crc_step({3'b000, crc} ^ w[23:16]);
    crc = crc_step({3'b000, crc} ^ w[31:24]);
    crc = crc ^ CRC_XOR_OUT;
    return {w[31:8], b0[7:5], crc};
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/rpfe_ifs.sv @@
`default_nettype none
interface rpfe_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] packet_word;

  modport source(output valid, output command, output packet_word, input ready);
  modport sink(input valid, input command, input packet_word, output ready);
endinterface

interface rpfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       gap_before;
  logic       last;

  modport source(output valid, output line_byte, output gap_before, output last,
                 input ready);
  modport sink(input valid, input line_byte, input gap_before, input last,
               output ready);
endinterface
`default_nettype wire

@@ rtl/core/rf_packet_frame_encoder.sv @@
// A send word passes a queue slot and the back end's frame register, then leaves as
// line bytes from the output register. Throughput: one line byte per cycle while
// out_ch.ready allows; 12 bytes per packet after idle, 10 when following a frame,
// limited by the single output byte register of the back end. Idle commands produce
// no words; a two-entry queue decouples input acceptance from line output.
// Synchronous active-low reset: line idle, join_frames set, queue and output empty.
`default_nettype none
module rf_packet_frame_encoder (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rpfe_in_if.sink    in_ch,
  rpfe_out_if.source out_ch,
  input  wire logic  cfg_wr_en,
  input  wire logic  cfg_wr_data
);
  import rpfe_pkg::*;

  logic   push_valid;
  logic   push_ready;
  entry_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_data;

  rpfe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  rpfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rpfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

@@ rtl/core/rpfe_front.sv @@
`default_nettype none
module rpfe_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  rpfe_in_if.sink              in_ch,
  input  wire logic            cfg_wr_en,
  input  wire logic            cfg_wr_data,
  output logic                 push_valid,
  input  wire logic            push_ready,
  output rpfe_pkg::entry_t     push_data
);
  import rpfe_pkg::*;

  logic join_frames_r;
  logic link_idle_r;
  logic link_idle_nxt;
  logic accept;

  // Idle commands are only bookkeeping, but they wait on the queue too so
  // that order against pending sends is kept.
  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = in_ch.valid && (in_ch.command == CMD_SEND);

  always_comb begin
    push_data.frame     = frame_packet(in_ch.packet_word);
    push_data.long_sync = link_idle_r;
    push_data.gap       = link_idle_r || !join_frames_r;
  end

  always_comb begin
    link_idle_nxt = link_idle_r;
    if (accept) begin
      link_idle_nxt = (in_ch.command == CMD_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      join_frames_r <= 1'b1;
      link_idle_r   <= 1'b1;
    end else begin
      link_idle_r <= link_idle_nxt;
      if (cfg_wr_en) begin
        join_frames_r <= cfg_wr_data;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/rpfe_queue.sv @@
`default_nettype none
module rpfe_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire rpfe_pkg::entry_t push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output rpfe_pkg::entry_t      pop_data
);
  import rpfe_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

  entry_t          slots_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            push;
  logic            pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/rpfe_back.sv @@
`default_nettype none
module rpfe_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pop_valid,
  output logic                  pop_ready,
  input  wire rpfe_pkg::entry_t pop_data,
  rpfe_out_if.source            out_ch
);
  import rpfe_pkg::*;

  entry_t     ent_r;
  logic       active_r;
  logic [3:0] cnt_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_gap_r;
  logic       out_last_r;

  logic       out_free;
  logic       produce;
  logic       done;
  logic       load;
  logic [3:0] start_pos;
  logic [3:0] code_idx;
  logic [3:0] nib;
  logic [7:0] byte_nxt;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign produce   = active_r && out_free;
  assign done      = produce && (cnt_r == LAST_IDX);
  // The next frame is taken on the same edge as the last byte of this one.
  assign load      = pop_valid && (!active_r || done);
  assign pop_ready = !active_r || done;

  assign start_pos = ent_r.long_sync ? LONG_START : SHORT_START;
  assign code_idx  = cnt_r - CODE_START;
  assign nib       = ent_r.frame[{code_idx[2:0], 2'b00} +: 4];
  assign byte_nxt  = (cnt_r < CODE_START) ? SYNC_BYTE : NIBBLE_CODE[nib];

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= pop_data;
    end
    if (produce) begin
      out_byte_r <= byte_nxt;
      out_gap_r  <= ent_r.gap && (cnt_r == start_pos);
      out_last_r <= (cnt_r == LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        active_r <= 1'b1;
        cnt_r    <= pop_data.long_sync ? LONG_START : SHORT_START;
      end else if (done) begin
        active_r <= 1'b0;
        cnt_r    <= '0;
      end else if (produce) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (produce) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.line_byte  = out_byte_r;
  assign out_ch.gap_before = out_gap_r;
  assign out_ch.last       = out_last_r;

`ifndef SYNTHESIS
  a_gap_on_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_gap_r) |-> (out_byte_r == SYNC_BYTE))
    else $error("gap flag on a coded byte");

  a_last_on_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_byte_r != SYNC_BYTE))
    else $error("last flag on a sync byte");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (cnt_r <= LAST_IDX))
    else $error("byte counter out of range");

  a_done_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (done && !pop_valid) |=> !active_r)
    else $error("back end kept running after the last byte");
`endif

endmodule
`default_nettype wire
